// ===== hdl/bls_pkg.sv =====
package bls_pkg;

	localparam int DEF_COORD_BITS  = 16;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int CLIP_BITS       = 15;
	localparam int COLOR_BITS      = 32;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIDTH  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_HEIGHT = CFG_IDX_BITS'(1);

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

endpackage

// ===== hdl/bls_ifs.sv =====
interface line_cmd_if import bls_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) ();
	logic                         valid;
	logic                         ready;
	op_t                          op;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [COLOR_BITS-1:0]        pixel_color;

	modport source (output valid, op, start_x, start_y, end_x, end_y, pixel_color,
		input ready);
	modport sink (input valid, op, start_x, start_y, end_x, end_y, pixel_color,
		output ready);
endinterface

interface point_if import bls_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic [COLOR_BITS-1:0]        point_color;
	logic                         visible;
	logic                         last;

	modport source (output valid, point_x, point_y, point_color, visible, last,
		input ready);
	modport sink (input valid, point_x, point_y, point_color, visible, last,
		output ready);
endinterface

interface cfg_if import bls_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bls_front.sv =====
module bls_front import bls_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	line_cmd_if.sink                     cmd,
	output logic                         push_valid,
	input  logic                         push_ready,
	output op_t                          op_s1,
	output logic signed [COORD_BITS-1:0] x0_s1,
	output logic signed [COORD_BITS-1:0] y0_s1,
	output logic signed [COORD_BITS-1:0] x1_s1,
	output logic signed [COORD_BITS-1:0] y1_s1,
	output logic signed [COORD_BITS:0]   dx_s1,
	output logic signed [COORD_BITS:0]   dyn_s1,
	output logic                         sxn_s1,
	output logic                         syn_s1,
	output logic [COLOR_BITS-1:0]        color_s1
);

	logic                       valid_s1;
	logic                       take;
	logic                       x_lt;
	logic                       y_lt;
	logic signed [COORD_BITS:0] diff_x;
	logic signed [COORD_BITS:0] diff_y;
	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dyn;

	assign cmd.ready  = !valid_s1 || push_ready;
	assign take       = cmd.valid && cmd.ready;
	assign push_valid = valid_s1;

	// classify the line direction and magnitudes up front
	always_comb begin
		x_lt   = cmd.start_x < cmd.end_x;
		y_lt   = cmd.start_y < cmd.end_y;
		diff_x = (COORD_BITS+1)'(cmd.end_x) - (COORD_BITS+1)'(cmd.start_x);
		diff_y = (COORD_BITS+1)'(cmd.end_y) - (COORD_BITS+1)'(cmd.start_y);
		dx     = x_lt ? diff_x : -diff_x;
		dyn    = y_lt ? -diff_y : diff_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= cmd.op;
			x0_s1    <= cmd.start_x;
			y0_s1    <= cmd.start_y;
			x1_s1    <= cmd.end_x;
			y1_s1    <= cmd.end_y;
			dx_s1    <= dx;
			dyn_s1   <= dyn;
			sxn_s1   <= !x_lt;
			syn_s1   <= !y_lt;
			color_s1 <= cmd.pixel_color;
		end
	end

endmodule

// ===== hdl/bls_queue.sv =====
module bls_queue import bls_pkg::*; #(
	parameter int DATA_BITS = 8,
	parameter int DEPTH     = DEF_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output logic [DATA_BITS-1:0] pop_data
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

	logic [DATA_BITS-1:0] store_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != CNT_BITS'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/bls_back.sv =====
module bls_back import bls_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cfg_if.sink                          cfg,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  op_t                          pop_op,
	input  logic signed [COORD_BITS-1:0] pop_x0,
	input  logic signed [COORD_BITS-1:0] pop_y0,
	input  logic signed [COORD_BITS-1:0] pop_x1,
	input  logic signed [COORD_BITS-1:0] pop_y1,
	input  logic signed [COORD_BITS:0]   pop_dx,
	input  logic signed [COORD_BITS:0]   pop_dyn,
	input  logic                         pop_sxn,
	input  logic                         pop_syn,
	input  logic [COLOR_BITS-1:0]        pop_color,
	point_if.source                      pnt
);

	localparam int EB = COORD_BITS + 3;
	localparam int CW = COORD_BITS + CLIP_BITS;

	logic [CLIP_BITS-1:0]         clip_w_q;
	logic [CLIP_BITS-1:0]         clip_h_q;
	logic signed [COORD_BITS-1:0] cursor_x_q;
	logic signed [COORD_BITS-1:0] cursor_y_q;
	logic signed [COORD_BITS-1:0] target_x_q;
	logic signed [COORD_BITS-1:0] target_y_q;
	logic signed [COORD_BITS:0]   dx_q;
	logic signed [COORD_BITS:0]   dyn_q;
	logic                         sxn_q;
	logic                         syn_q;
	logic signed [EB-1:0]         err_q;
	logic                         active_q;
	logic [COLOR_BITS-1:0]        color_q;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] out_x_q;
	logic signed [COORD_BITS-1:0] out_y_q;
	logic [COLOR_BITS-1:0]        out_color_q;
	logic                         out_vis_q;
	logic                         out_last_q;

	logic                         is_start;
	logic                         drop;
	logic                         out_free;
	logic                         fire;
	logic signed [EB:0]           e2;
	logic                         move_x;
	logic                         move_y;
	logic signed [EB-1:0]         err_step;
	logic signed [COORD_BITS-1:0] step_x;
	logic signed [COORD_BITS-1:0] step_y;
	logic signed [COORD_BITS-1:0] nxt_x;
	logic signed [COORD_BITS-1:0] nxt_y;
	logic signed [COORD_BITS-1:0] tgt_x;
	logic signed [COORD_BITS-1:0] tgt_y;
	logic                         at_end;
	logic                         vis;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_w_q <= '0;
			clip_h_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_CLIP_WIDTH) begin
				clip_w_q <= cfg.data[CLIP_BITS-1:0];
			end
			if (cfg.index == REG_CLIP_HEIGHT) begin
				clip_h_q <= cfg.data[CLIP_BITS-1:0];
			end
		end
	end

	// a step with no line in progress is dropped without waiting on the output
	assign is_start  = pop_op == OP_START;
	assign drop      = !is_start && !active_q;
	assign out_free  = !out_valid_q || pnt.ready;
	assign pop_ready = out_free || drop;
	assign fire      = pop_valid && pop_ready && !drop;

	always_comb begin
		e2       = {err_q, 1'b0};
		move_x   = e2 >= (EB+1)'(dyn_q);
		move_y   = e2 <= (EB+1)'(dx_q);
		err_step = err_q + (move_x ? EB'(dyn_q) : EB'(0)) + (move_y ? EB'(dx_q) : EB'(0));
		step_x   = cursor_x_q;
		step_y   = cursor_y_q;
		if (move_x) begin
			step_x = sxn_q ? cursor_x_q - COORD_BITS'(1) : cursor_x_q + COORD_BITS'(1);
		end
		if (move_y) begin
			step_y = syn_q ? cursor_y_q - COORD_BITS'(1) : cursor_y_q + COORD_BITS'(1);
		end
		nxt_x  = is_start ? pop_x0 : step_x;
		nxt_y  = is_start ? pop_y0 : step_y;
		tgt_x  = is_start ? pop_x1 : target_x_q;
		tgt_y  = is_start ? pop_y1 : target_y_q;
		at_end = (nxt_x == tgt_x) && (nxt_y == tgt_y);
		vis    = !nxt_x[COORD_BITS-1] && !nxt_y[COORD_BITS-1] &&
			({{CLIP_BITS{1'b0}}, nxt_x} < CW'(clip_w_q)) &&
			({{CLIP_BITS{1'b0}}, nxt_y} < CW'(clip_h_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				active_q    <= !at_end;
				out_valid_q <= 1'b1;
			end else if (pnt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cursor_x_q  <= nxt_x;
			cursor_y_q  <= nxt_y;
			out_x_q     <= nxt_x;
			out_y_q     <= nxt_y;
			out_vis_q   <= vis;
			out_last_q  <= at_end;
			out_color_q <= is_start ? pop_color : color_q;
			if (is_start) begin
				target_x_q <= pop_x1;
				target_y_q <= pop_y1;
				dx_q       <= pop_dx;
				dyn_q      <= pop_dyn;
				sxn_q      <= pop_sxn;
				syn_q      <= pop_syn;
				err_q      <= EB'(pop_dx) + EB'(pop_dyn);
				color_q    <= pop_color;
			end else begin
				err_q <= err_step;
			end
		end
	end

	assign pnt.valid       = out_valid_q;
	assign pnt.point_x     = out_x_q;
	assign pnt.point_y     = out_y_q;
	assign pnt.point_color = out_color_q;
	assign pnt.visible     = out_vis_q;
	assign pnt.last        = out_last_q;

endmodule

// ===== hdl/bresenham_line_stepper.sv =====
// channel | dir | contents
// --------+-----+-------------------------------------------------------------
// cmd     | in  | op, start_x, start_y, end_x, end_y, pixel_color
// pnt     | out | point_x, point_y, point_color, visible, last
// cfg     | in  | index (0 clip_width, 1 clip_height), data; always ready
//
// One item per clock sustained while pnt is ready; the rate is set by the back
// stepper, whose error-term update and cursor move are combinational.
// A point is offered on pnt after its cmd transaction has passed the front
// register, the command queue and the output register, in that order.
// Reset clears the queue, the line-active flag, the output valid and the clip
// registers. A stalled pnt holds its point, then fills the queue, then drops
// cmd.ready; a step with no line in progress is discarded without a stall.
module bresenham_line_stepper import bls_pkg::*; #(
	parameter int COORD_BITS  = DEF_COORD_BITS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	line_cmd_if.sink cmd,
	cfg_if.sink      cfg,
	point_if.source  pnt
);

	localparam int ENTRY_BITS = 1 + 2 + 2 * (COORD_BITS + 1) + 4 * COORD_BITS + COLOR_BITS;

	logic                         push_valid;
	logic                         push_ready;
	logic                         pop_valid;
	logic                         pop_ready;
	logic [ENTRY_BITS-1:0]        push_data;
	logic [ENTRY_BITS-1:0]        pop_data;

	op_t                          f_op;
	logic signed [COORD_BITS-1:0] f_x0, f_y0, f_x1, f_y1;
	logic signed [COORD_BITS:0]   f_dx, f_dyn;
	logic                         f_sxn, f_syn;
	logic [COLOR_BITS-1:0]        f_color;

	op_t                          b_op;
	logic                         b_op_raw;
	logic signed [COORD_BITS-1:0] b_x0, b_y0, b_x1, b_y1;
	logic signed [COORD_BITS:0]   b_dx, b_dyn;
	logic                         b_sxn, b_syn;
	logic [COLOR_BITS-1:0]        b_color;

	bls_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.op_s1     (f_op),
		.x0_s1     (f_x0),
		.y0_s1     (f_y0),
		.x1_s1     (f_x1),
		.y1_s1     (f_y1),
		.dx_s1     (f_dx),
		.dyn_s1    (f_dyn),
		.sxn_s1    (f_sxn),
		.syn_s1    (f_syn),
		.color_s1  (f_color)
	);

	assign push_data = {f_op, f_sxn, f_syn, f_dx, f_dyn, f_x0, f_y0, f_x1, f_y1, f_color};

	bls_queue #(
		.DATA_BITS(ENTRY_BITS),
		.DEPTH    (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	assign {b_op_raw, b_sxn, b_syn, b_dx, b_dyn, b_x0, b_y0, b_x1, b_y1, b_color} = pop_data;
	assign b_op = op_t'(b_op_raw);

	bls_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_op   (b_op),
		.pop_x0   (b_x0),
		.pop_y0   (b_y0),
		.pop_x1   (b_x1),
		.pop_y1   (b_y1),
		.pop_dx   (b_dx),
		.pop_dyn  (b_dyn),
		.pop_sxn  (b_sxn),
		.pop_syn  (b_syn),
		.pop_color(b_color),
		.pnt      (pnt)
	);

endmodule

// ===== hdl/bls_checker.sv =====
module bls_checker import bls_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pnt_valid,
	input logic                  pnt_ready,
	input logic [COORD_BITS-1:0] pnt_x,
	input logic [COORD_BITS-1:0] pnt_y,
	input logic [COLOR_BITS-1:0] pnt_color,
	input logic                  pnt_visible,
	input logic                  pnt_last
);

	// a visible point never has a negative coordinate
	assert property (@(posedge clk) disable iff (!arst_n)
		pnt_valid && pnt_visible |-> !pnt_x[COORD_BITS-1] && !pnt_y[COORD_BITS-1])
		else $error("visible point with negative coordinate");

	// nothing is offered while reset is held
	assert property (@(posedge clk) !arst_n |-> !pnt_valid)
		else $error("point offered during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		pnt_valid && !pnt_ready |=> pnt_valid)
		else $error("point withdrawn while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		pnt_valid && !pnt_ready |=> $stable(pnt_x) && $stable(pnt_y) &&
			$stable(pnt_color) && $stable(pnt_visible) && $stable(pnt_last))
		else $error("point changed while stalled");

endmodule

bind bresenham_line_stepper bls_checker #(
	.COORD_BITS(COORD_BITS)
) u_bls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pnt_valid  (pnt.valid),
	.pnt_ready  (pnt.ready),
	.pnt_x      (pnt.point_x),
	.pnt_y      (pnt.point_y),
	.pnt_color  (pnt.point_color),
	.pnt_visible(pnt.visible),
	.pnt_last   (pnt.last)
);

// ===== test/bresenham_line_stepper_tb.sv =====
module bresenham_line_stepper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bls_pkg::*;

	localparam int CB          = DEF_COORD_BITS;
	localparam int CMAX        = 2 ** (CB - 1) - 1;
	localparam int CMIN        = -(2 ** (CB - 1));
	localparam int PIPE_PAD    = 10;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = CFG_IDX_BITS'(3);

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		op_t                   op;
		coord_t                x0;
		coord_t                y0;
		coord_t                x1;
		coord_t                y1;
		logic [COLOR_BITS-1:0] color;
	} line_cmd_t;

	typedef struct {
		coord_t                x;
		coord_t                y;
		logic [COLOR_BITS-1:0] color;
		logic                  visible;
		logic                  last;
	} point_t;

	logic clk;
	logic arst_n;

	line_cmd_if #(.COORD_BITS(CB)) cmd_bus ();
	point_if #(.COORD_BITS(CB))    pnt_bus ();
	cfg_if                         cfg_bus ();

	bresenham_line_stepper #(.COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.cfg    (cfg_bus),
		.pnt    (pnt_bus)
	);

	// line tracer state
	coord_t                cur_x, cur_y, tgt_x, tgt_y;
	logic signed [CB+1:0]  span_x, span_y_neg;
	logic signed [CB+2:0]  err;
	logic                  back_x, back_y;
	logic                  drawing;
	logic [COLOR_BITS-1:0] line_color;
	logic [CLIP_BITS-1:0]  clip_w, clip_h;

	line_cmd_t cmd_pending[$];
	line_cmd_t cmd_on_bus;
	point_t    points_due[$];
	int        cmds_outstanding;
	int        stim_points;
	int        mismatches;
	int        cycles;
	int        send_gap_pct;
	int        recv_gap_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic plot_next_point(input line_cmd_t c);
		logic signed [CB+1:0] ax0, ay0, ax1, ay1;
		logic signed [CB+3:0] e2;
		point_t               p;
		ax0 = (CB+2)'(c.x0);
		ay0 = (CB+2)'(c.y0);
		ax1 = (CB+2)'(c.x1);
		ay1 = (CB+2)'(c.y1);
		if (c.op == OP_START || drawing) begin
			if (c.op == OP_START) begin
				cur_x      = c.x0;
				cur_y      = c.y0;
				tgt_x      = c.x1;
				tgt_y      = c.y1;
				span_x     = (ax1 >= ax0) ? ax1 - ax0 : ax0 - ax1;
				span_y_neg = (ay1 >= ay0) ? ay0 - ay1 : ay1 - ay0;
				back_x     = !(c.x0 < c.x1);
				back_y     = !(c.y0 < c.y1);
				err        = (CB+3)'(span_x) + (CB+3)'(span_y_neg);
				line_color = c.color;
			end else begin
				// both moves are decided on the same doubled error
				e2 = (CB+4)'(err);
				e2 = e2 <<< 1;
				if (e2 >= (CB+4)'(span_y_neg)) begin
					err   = err + (CB+3)'(span_y_neg);
					cur_x = back_x ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
				end
				if (e2 <= (CB+4)'(span_x)) begin
					err   = err + (CB+3)'(span_x);
					cur_y = back_y ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
				end
			end
			drawing   = !(cur_x == tgt_x && cur_y == tgt_y);
			p.x       = cur_x;
			p.y       = cur_y;
			p.color   = line_color;
			p.visible = !cur_x[CB-1] &&
				((CB+CLIP_BITS)'($unsigned(cur_x)) < (CB+CLIP_BITS)'(clip_w)) &&
				!cur_y[CB-1] &&
				((CB+CLIP_BITS)'($unsigned(cur_y)) < (CB+CLIP_BITS)'(clip_h));
			p.last    = !drawing;
			points_due.push_back(p);
		end
	endtask

	// driver: present the next pending command once the slot is free
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				plot_next_point(cmd_on_bus);
				cmds_outstanding--;
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (cmd_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					cmd_on_bus = cmd_pending.pop_front();
					cmd_bus.valid       <= 1'b1;
					cmd_bus.op          <= cmd_on_bus.op;
					cmd_bus.start_x     <= cmd_on_bus.x0;
					cmd_bus.start_y     <= cmd_on_bus.y0;
					cmd_bus.end_x       <= cmd_on_bus.x1;
					cmd_bus.end_y       <= cmd_on_bus.y1;
					cmd_bus.pixel_color <= cmd_on_bus.color;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each point transaction with the oldest one due
	always @(posedge clk) begin
		point_t want;
		if (arst_n) begin
			if (pnt_bus.valid && pnt_bus.ready) begin
				if (points_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected point x=%0d y=%0d color=%h vis=%b last=%b",
							pnt_bus.point_x, pnt_bus.point_y, pnt_bus.point_color,
							pnt_bus.visible, pnt_bus.last);
					mismatches++;
				end else begin
					want = points_due.pop_front();
					if (pnt_bus.point_x !== want.x || pnt_bus.point_y !== want.y ||
						pnt_bus.point_color !== want.color ||
						pnt_bus.visible !== want.visible || pnt_bus.last !== want.last) begin
						if (mismatches < 10)
							$display("point mismatch: exp x=%0d y=%0d color=%h vis=%b last=%b, got x=%0d y=%0d color=%h vis=%b last=%b",
								want.x, want.y, want.color, want.visible, want.last,
								pnt_bus.point_x, pnt_bus.point_y, pnt_bus.point_color,
								pnt_bus.visible, pnt_bus.last);
						mismatches++;
					end
				end
			end
			pnt_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[bresenham_line_stepper] ERROR");
			$finish;
		end
	end

	task automatic push_cmd(input line_cmd_t c);
		cmd_pending.push_back(c);
		cmds_outstanding++;
	endtask

	function automatic line_cmd_t junk_step();
		line_cmd_t c;
		c.op    = OP_STEP;
		c.x0    = coord_t'($urandom);
		c.y0    = coord_t'($urandom);
		c.x1    = coord_t'($urandom);
		c.y1    = coord_t'($urandom);
		c.color = $urandom;
		return c;
	endfunction

	function automatic int clamp_coord(input int v);
		return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
	endfunction

	// a start and a number of steps; steps past the last point are not counted
	task automatic queue_line(input int x0, input int y0, input int x1, input int y1,
		input logic [COLOR_BITS-1:0] color, input int steps);
		line_cmd_t c;
		int        adx, ady, span;
		adx     = (x1 >= x0) ? x1 - x0 : x0 - x1;
		ady     = (y1 >= y0) ? y1 - y0 : y0 - y1;
		span    = (adx > ady) ? adx : ady;
		c.op    = OP_START;
		c.x0    = coord_t'(x0);
		c.y0    = coord_t'(y0);
		c.x1    = coord_t'(x1);
		c.y1    = coord_t'(y1);
		c.color = color;
		push_cmd(c);
		stim_points++;
		for (int i = 0; i < steps; i++) begin
			push_cmd(junk_step());
			if (i < span)
				stim_points++;
		end
	endtask

	task automatic queue_random_lines(input int goal);
		int x0, y0, x1, y1, kind, adx, ady, span, steps, pick, stop;
		stop = stim_points + goal;
		while (stim_points < stop) begin
			kind = $urandom_range(99);
			if (kind >= 96) begin
				push_cmd(junk_step());
			end else begin
				if (kind < 65) begin
					x0 = $urandom_range(46) - 6;
					y0 = $urandom_range(46) - 6;
					x1 = x0 + $urandom_range(24) - 12;
					y1 = y0 + $urandom_range(24) - 12;
				end else if (kind < 78) begin
					x0 = int'(coord_t'($urandom));
					y0 = int'(coord_t'($urandom));
					x1 = int'(coord_t'($urandom));
					y1 = int'(coord_t'($urandom));
				end else if (kind < 88) begin
					x0 = int'(coord_t'($urandom));
					y0 = int'(coord_t'($urandom));
					x1 = clamp_coord(x0 + $urandom_range(12) - 6);
					y1 = clamp_coord(y0 + $urandom_range(12) - 6);
				end else begin
					x0 = $urandom_range(1) ? int'(coord_t'($urandom)) : $urandom_range(20) - 4;
					y0 = $urandom_range(1) ? int'(coord_t'($urandom)) : $urandom_range(20) - 4;
					x1 = x0;
					y1 = y0;
				end
				adx  = (x1 >= x0) ? x1 - x0 : x0 - x1;
				ady  = (y1 >= y0) ? y1 - y0 : y0 - y1;
				span = (adx > ady) ? adx : ady;
				pick = $urandom_range(99);
				if (span > 40)
					steps = $urandom_range(12);
				else if (pick < 70)
					steps = span;
				else if (pick < 85)
					steps = span + $urandom_range(3, 1);
				else
					steps = $urandom_range(span);
				queue_line(x0, y0, x1, y1, $urandom, steps);
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (cmds_outstanding != 0 || points_due.size() != 0);
	endtask

	// drain, then let any discarded step leave the pipeline
	task automatic settle();
		wait_drained();
		repeat (PIPE_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk);
		while (!cfg_bus.ready);
		case (idx)
			REG_CLIP_WIDTH:  clip_w = value[CLIP_BITS-1:0];
			REG_CLIP_HEIGHT: clip_h = value[CLIP_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_clip(input logic [CFG_DATA_BITS-1:0] w,
		input logic [CFG_DATA_BITS-1:0] h);
		write_reg(REG_CLIP_WIDTH, w);
		write_reg(REG_CLIP_HEIGHT, h);
		write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_BITS'($urandom));
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.op          = OP_START;
		cmd_bus.start_x     = '0;
		cmd_bus.start_y     = '0;
		cmd_bus.end_x       = '0;
		cmd_bus.end_y       = '0;
		cmd_bus.pixel_color = '0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = REG_CLIP_WIDTH;
		cfg_bus.data        = '0;
		pnt_bus.ready       = 1'b0;
		cur_x               = '0;
		cur_y               = '0;
		tgt_x               = '0;
		tgt_y               = '0;
		span_x              = '0;
		span_y_neg          = '0;
		err                 = '0;
		back_x              = 1'b0;
		back_y              = 1'b0;
		drawing             = 1'b0;
		line_color          = '0;
		clip_w              = '0;
		clip_h              = '0;
		cmds_outstanding    = 0;
		stim_points         = 0;
		mismatches          = 0;
		cycles              = 0;
		send_gap_pct        = 19;
		recv_gap_pct        = 68;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// clip still at reset: nothing visible; stray steps before and after a line
		push_cmd(junk_step());
		queue_line(0, 0, 0, 0, 32'h0000_0000, 1);
		queue_line(0, 0, 2, 1, 32'hFFFF_FFFF, 2);
		settle();
		set_clip(16'h800A, 16'h0006);
		// full-range diagonals, abandoned by the next start
		queue_line(CMIN, CMAX, CMAX, CMIN, 32'hA5A5_5A5A, 2);
		queue_line(CMAX, CMIN, CMIN, CMAX, 32'h5A5A_A5A5, 1);
		queue_line(9, 5, 5, 1, $urandom, 4);
		queue_line(1, -1, 0, 2, $urandom, 3);
		queue_line(10, 5, 8, 5, $urandom, 2);
		queue_line(3, 6, 3, 4, $urandom, 2);
		settle();

		stim_points = 0;
		set_clip(16'hFFFF, 16'h7FFF);
		queue_random_lines(150);
		settle();
		set_clip(16'h8000, 16'hFFFF);
		queue_random_lines(50);
		settle();

		send_gap_pct = 68;
		recv_gap_pct = 19;
		set_clip(CFG_DATA_BITS'($urandom_range(48, 1)), CFG_DATA_BITS'($urandom_range(48, 1)));
		queue_random_lines(75);
		// hold off until every point due has arrived
		wait_drained();
		queue_random_lines(75);
		settle();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		set_clip(16'h7FFF, 16'h0000);
		queue_random_lines(50);
		settle();
		set_clip(CFG_DATA_BITS'($urandom_range(40, 1)), CFG_DATA_BITS'($urandom_range(40, 1)));
		queue_random_lines(200);
		settle();

		if (mismatches == 0 && points_due.size() == 0)
			$display("[bresenham_line_stepper] OK");
		else
			$display("[bresenham_line_stepper] ERROR");
		$finish;
	end

endmodule
